// File: rtl/oair_pkg.sv
// ============================================================================
// oair_pkg - shared types and codes of the ordered array unit
// command codes, status codes, controller states and control/status bundles
// ============================================================================
package oair_pkg;

    // stream word widths, whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 9;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LCNT_W  = 9;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // what an accepted command turns into
    typedef enum logic [2:0] {
        K_NONE,
        K_GET,
        K_SET,
        K_PUSH,
        K_POP,
        K_INSERT,
        K_INS_END,
        K_REMOVE
    } t_kind;

    // datapath memory operation for one cycle
    typedef enum logic [3:0] {
        M_NONE,
        M_GET_RD,
        M_SET,
        M_PUSH,
        M_POP,
        M_UP_RD,
        M_UP_WR,
        M_DN_RD,
        M_DN_WR,
        M_INS,
        M_REM
    } t_mem_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_INS_FIN,
        S_REM_FIN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    accept;
        t_mem_op mem_op;
        logic    capture;
        logic    out_load;
    } t_ctrl;

    typedef struct packed {
        t_kind kind;
        logic  rem_end;
        logic  up_last;
        logic  dn_last;
        logic  out_free;
    } t_stat;

endpackage

// File: rtl/ordered_array_insert_remove_unit.sv
// ============================================================================
// ordered_array_insert_remove_unit - bounded ordered array with live count
// get, set, push, pop, insert and remove on a ram-backed element store
// ============================================================================
//
// channel   dir   word fields (lowest bit up)
// --------  ----  ---------------------------------------------------------
// s_axis    in    cmd[2:0], position[11:3], write_value[43:12], zero pad
// m_axis    out   read_value[31:0], status[33:32], live_count[42:34], pad
//
// one command at a time; set, push, pop and rejected commands go straight to
// the result, get adds a registered ram read; insert and remove shift the
// elements between position and the count, each moved element being read and
// then written one place over on the single element ram port pair
// reset clears the live count and the result valid flag; the element ram is
// not cleared, entries at or above the count are never read
// a held result does not block the next command word; only loading a new
// result waits for m_axis_tready
//
module ordered_array_insert_remove_unit #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd, position, write_value, zero pad
    input  logic [oair_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_value, status, live_count, zero pad
    output logic [oair_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int IN_USED  = oair_pkg::CMD_W + oair_pkg::POS_W + oair_pkg::VAL_W;
    localparam int OUT_USED = oair_pkg::VAL_W + oair_pkg::STAT_W + oair_pkg::LCNT_W;

    oair_pkg::t_ctrl                 ctrl;
    oair_pkg::t_stat                 stat;
    logic [oair_pkg::CMD_W-1:0]      cmd;
    logic [oair_pkg::POS_W-1:0]      position;
    logic [oair_pkg::VAL_W-1:0]      write_value;
    logic [oair_pkg::VAL_W-1:0]      read_value;
    logic [oair_pkg::STAT_W-1:0]     status;
    logic [oair_pkg::LCNT_W-1:0]     live_count;

    // unpack the command word
    assign cmd         = s_axis_tdata[oair_pkg::CMD_W-1:0];
    assign position    = s_axis_tdata[oair_pkg::CMD_W +: oair_pkg::POS_W];
    assign write_value = s_axis_tdata[oair_pkg::CMD_W + oair_pkg::POS_W +: oair_pkg::VAL_W];

    oair_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    oair_dp #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_cmd        (cmd),
        .i_pos        (position),
        .i_wval       (write_value),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_read_value (read_value),
        .o_status     (status),
        .o_live_count (live_count)
    );

    // pack the result word, pad bits zero
    assign m_axis_tdata = {{(oair_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                           live_count, status, read_value};

`ifndef SYNTHESIS
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[oair_pkg::OUT_TDATA_W-1:OUT_USED] == '0))
        else $error("result pad bits not zero");

    a_get_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status != oair_pkg::ST_OK)) |-> (read_value == '0))
        else $error("read value set on a rejected command");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second command taken while one is in work");

    a_in_used_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IN_USED <= oair_pkg::IN_TDATA_W)
        else $error("command fields exceed word width");
`endif

endmodule

// File: rtl/oair_ram.sv
// ============================================================================
// oair_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ============================================================================
module oair_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/oair_ctrl.sv
// ============================================================================
// oair_ctrl - command sequencer of the ordered array unit
// steps gets, shifts and result hand-off through the datapath
// ============================================================================
module oair_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  oair_pkg::t_stat i_stat,
    output oair_pkg::t_ctrl o_ctrl
);

    oair_pkg::t_state r_state;
    oair_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oair_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            oair_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_stat.kind)
                        oair_pkg::K_GET:     n_state = oair_pkg::S_READ;
                        oair_pkg::K_INSERT:  n_state = oair_pkg::S_UP_RD;
                        oair_pkg::K_INS_END: n_state = oair_pkg::S_INS_FIN;
                        oair_pkg::K_REMOVE: begin
                            n_state = i_stat.rem_end ? oair_pkg::S_REM_FIN
                                                     : oair_pkg::S_DN_RD;
                        end
                        default:             n_state = oair_pkg::S_RESP;
                    endcase
                end
            end
            oair_pkg::S_READ:    n_state = oair_pkg::S_RESP;
            oair_pkg::S_UP_RD:   n_state = oair_pkg::S_UP_WR;
            oair_pkg::S_UP_WR: begin
                n_state = i_stat.up_last ? oair_pkg::S_INS_FIN : oair_pkg::S_UP_RD;
            end
            oair_pkg::S_DN_RD:   n_state = oair_pkg::S_DN_WR;
            oair_pkg::S_DN_WR: begin
                n_state = i_stat.dn_last ? oair_pkg::S_REM_FIN : oair_pkg::S_DN_RD;
            end
            oair_pkg::S_INS_FIN: n_state = oair_pkg::S_RESP;
            oair_pkg::S_REM_FIN: n_state = oair_pkg::S_RESP;
            oair_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = oair_pkg::S_IDLE;
                end
            end
            default:             n_state = oair_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready         = 1'b0;
        o_ctrl.accept   = 1'b0;
        o_ctrl.mem_op   = oair_pkg::M_NONE;
        o_ctrl.capture  = 1'b0;
        o_ctrl.out_load = 1'b0;
        case (r_state)
            oair_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.accept = 1'b1;
                    case (i_stat.kind)
                        oair_pkg::K_GET:  o_ctrl.mem_op = oair_pkg::M_GET_RD;
                        oair_pkg::K_SET:  o_ctrl.mem_op = oair_pkg::M_SET;
                        oair_pkg::K_PUSH: o_ctrl.mem_op = oair_pkg::M_PUSH;
                        oair_pkg::K_POP:  o_ctrl.mem_op = oair_pkg::M_POP;
                        default:          o_ctrl.mem_op = oair_pkg::M_NONE;
                    endcase
                end
            end
            oair_pkg::S_READ:    o_ctrl.capture  = 1'b1;
            oair_pkg::S_UP_RD:   o_ctrl.mem_op   = oair_pkg::M_UP_RD;
            oair_pkg::S_UP_WR:   o_ctrl.mem_op   = oair_pkg::M_UP_WR;
            oair_pkg::S_DN_RD:   o_ctrl.mem_op   = oair_pkg::M_DN_RD;
            oair_pkg::S_DN_WR:   o_ctrl.mem_op   = oair_pkg::M_DN_WR;
            oair_pkg::S_INS_FIN: o_ctrl.mem_op   = oair_pkg::M_INS;
            oair_pkg::S_REM_FIN: o_ctrl.mem_op   = oair_pkg::M_REM;
            oair_pkg::S_RESP:    o_ctrl.out_load = i_stat.out_free;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/oair_dp.sv
// ============================================================================
// oair_dp - datapath of the ordered array unit
// element ram, live count, command decode, shift index and result register
// ============================================================================
module oair_dp #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oair_pkg::t_ctrl               i_ctrl,
    output oair_pkg::t_stat               o_stat,
    input  logic [oair_pkg::CMD_W-1:0]    i_cmd,
    input  logic [oair_pkg::POS_W-1:0]    i_pos,
    input  logic [oair_pkg::VAL_W-1:0]    i_wval,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [oair_pkg::VAL_W-1:0]    o_read_value,
    output logic [oair_pkg::STAT_W-1:0]   o_status,
    output logic [oair_pkg::LCNT_W-1:0]   o_live_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > oair_pkg::POS_W) ? CW : oair_pkg::POS_W;
    localparam int EW = ELEM_WIDTH;

    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    logic [AW-1:0]                  r_idx;
    logic [AW-1:0]                  r_pos;
    logic [EW-1:0]                  r_val;
    logic [EW-1:0]                  r_rd;
    logic [oair_pkg::STAT_W-1:0]    r_status;
    logic                           r_out_valid;
    logic [oair_pkg::VAL_W-1:0]     r_out_rd;
    logic [oair_pkg::STAT_W-1:0]    r_out_st;
    logic [oair_pkg::LCNT_W-1:0]    r_out_cnt;

    logic [PW-1:0]                  pos_x;
    logic [PW-1:0]                  cnt_x;
    logic                           full;
    oair_pkg::t_kind                kind;
    logic [oair_pkg::STAT_W-1:0]    status;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [EW-1:0]                  ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [EW-1:0]                  ram_q;
    logic                           idx_dec;
    logic                           idx_inc;

    // command decode against the live count
    assign pos_x = PW'(i_pos);
    assign cnt_x = PW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));

    always_comb begin
        kind   = oair_pkg::K_NONE;
        status = oair_pkg::ST_OK;
        case (i_cmd)
            oair_pkg::CMD_GET: begin
                if (pos_x >= cnt_x) status = oair_pkg::ST_RANGE;
                else                kind   = oair_pkg::K_GET;
            end
            oair_pkg::CMD_SET: begin
                if (pos_x >= cnt_x) status = oair_pkg::ST_RANGE;
                else                kind   = oair_pkg::K_SET;
            end
            oair_pkg::CMD_PUSH: begin
                if (full) status = oair_pkg::ST_FULL;
                else      kind   = oair_pkg::K_PUSH;
            end
            oair_pkg::CMD_POP: begin
                if (r_count == '0) status = oair_pkg::ST_EMPTY;
                else               kind   = oair_pkg::K_POP;
            end
            oair_pkg::CMD_INSERT: begin
                if (pos_x > cnt_x)       status = oair_pkg::ST_RANGE;
                else if (full)           status = oair_pkg::ST_FULL;
                else if (pos_x == cnt_x) kind   = oair_pkg::K_INS_END;
                else                     kind   = oair_pkg::K_INSERT;
            end
            oair_pkg::CMD_REMOVE: begin
                if (pos_x >= cnt_x) status = oair_pkg::ST_RANGE;
                else                kind   = oair_pkg::K_REMOVE;
            end
            default: begin
                kind = oair_pkg::K_NONE;
            end
        endcase
    end

    assign o_stat.kind     = kind;
    assign o_stat.rem_end  = (pos_x + PW'(1) == cnt_x);
    assign o_stat.up_last  = ((r_idx - AW'(1)) == r_pos);
    assign o_stat.dn_last  = ((CW'(r_idx) + CW'(2)) == r_count);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // memory port and count steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_q;
        ram_raddr = r_idx;
        n_count   = r_count;
        idx_dec   = 1'b0;
        idx_inc   = 1'b0;
        case (i_ctrl.mem_op)
            oair_pkg::M_GET_RD: ram_raddr = AW'(i_pos);
            oair_pkg::M_SET: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(i_pos);
                ram_wdata = EW'(i_wval);
            end
            oair_pkg::M_PUSH: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_count);
                ram_wdata = EW'(i_wval);
                n_count   = r_count + CW'(1);
            end
            oair_pkg::M_POP: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_count - CW'(1));
                ram_wdata = '0;
                n_count   = r_count - CW'(1);
            end
            oair_pkg::M_UP_RD: ram_raddr = r_idx - AW'(1);
            oair_pkg::M_UP_WR: begin
                ram_we  = 1'b1;
                idx_dec = 1'b1;
            end
            oair_pkg::M_DN_RD: ram_raddr = r_idx + AW'(1);
            oair_pkg::M_DN_WR: begin
                ram_we  = 1'b1;
                idx_inc = 1'b1;
            end
            oair_pkg::M_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
            end
            oair_pkg::M_REM: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_count - CW'(1));
                ram_wdata = '0;
                n_count   = r_count - CW'(1);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    oair_ram #(
        .WIDTH (EW),
        .DEPTH (1 << AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command word and shift index, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_pos    <= AW'(i_pos);
            r_val    <= EW'(i_wval);
            r_status <= status;
            r_rd     <= '0;
            // insert walks down from the top, remove walks up from the hole
            r_idx    <= (i_cmd == oair_pkg::CMD_INSERT) ? AW'(r_count) : AW'(i_pos);
        end else begin
            if (i_ctrl.capture) begin
                r_rd <= ram_q;
            end
            if (idx_dec) begin
                r_idx <= r_idx - AW'(1);
            end else if (idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
        end
        if (i_ctrl.out_load) begin
            r_out_rd  <= oair_pkg::VAL_W'(r_rd);
            r_out_st  <= r_status;
            r_out_cnt <= oair_pkg::LCNT_W'(r_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_status     = r_out_st;
    assign o_live_count = r_out_cnt;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("live count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("live count moved by more than one");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (i_ctrl.mem_op == oair_pkg::M_UP_WR)) |-> (CW'(ram_waddr) <= r_count))
        else $error("shift write beyond live range");
`endif

endmodule
